FILE: src/ggs_pkg.sv
// ----------------------------------------------------------------------------
// Gaussian gridding spreader package
// Shared payload types, codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package ggs_pkg;

    localparam int DEF_MAX_GRID   = 64;
    localparam int DEF_MAX_SPREAD = 8;

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_SPREAD = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;
    // Spare action code; the block takes the item and does nothing with it.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [1:0] CFG_GRID_SIZE = 2'd0;
    localparam logic [1:0] CFG_SPREAD    = 2'd1;

    localparam logic [6:0] GRID_SIZE_RESET = 7'd64;
    localparam logic [3:0] SPREAD_RESET    = 4'd6;

    localparam logic [31:0] Q16_ONE = 32'h0001_0000;
    localparam logic [31:0] SAT32   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]         action;
        logic [3:0]         tap_index;
        logic [16:0]        tap_value;
        logic signed [15:0] sample_re;
        logic signed [15:0] sample_im;
        logic [5:0]         row;
        logic [5:0]         col;
        logic [17:0]        decay_x;
        logic [17:0]        decay_y;
    } in_item_t;

    typedef struct packed {
        logic signed [47:0] cell_re;
        logic signed [47:0] cell_im;
    } out_item_t;

    // Multiply operations of the kernel weight builder.
    typedef enum logic [1:0] {
        OP_PP,
        OP_PN,
        OP_WP,
        OP_WN
    } op_t;

    typedef struct packed {
        logic accept;
        logic clear;
        logic reduce;
        logic div_start;
        logic winit;
        logic mul_go;
        logic wb_go;
        op_t  op;
        logic axis;
        logic pos_init;
        logic issue;
        logic row_reset;
        logic row_step;
        logic row_odd;
        logic col_step;
        logic col_odd;
        logic rd_issue;
        logic capture;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic reduced;
        logic div_done;
        logic hazard;
        logic pipe_busy;
    } sts_t;

endpackage

FILE: src/gaussian_gridding_2d_spreader_unit.sv
// ----------------------------------------------------------------------------
// Gaussian gridding 2D spreader unit
// Spreads complex samples onto a saturating complex grid with a separable
// fast Gaussian kernel; cells are read out and cleared on request.
// ----------------------------------------------------------------------------
// A tap load is stored when the item is accepted. A cell read takes the row
// and column reduction, reads the cell, then captures and clears it, and its
// result strobes in the cycle after the capture. A spread takes the reduction,
// then per axis divider and shared-multiplier weight building, then a setup
// step and (2*msp)^2 accumulate issues, one per cycle through the grid memory
// port except while an issue stalls because wrapped offsets revisit a cell
// still in the accumulate pipeline, and a drain of that pipeline. After reset
// the grid is cleared, one cell a cycle, with busy high; configuration writes
// are taken at all times.
module gaussian_gridding_2d_spreader_unit #(
    parameter int MAX_GRID   = ggs_pkg::DEF_MAX_GRID,
    parameter int MAX_SPREAD = ggs_pkg::DEF_MAX_SPREAD
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ggs_pkg::in_item_t  item,
    output ggs_pkg::out_item_t result,
    output logic               result_valid,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [6:0]         cfg_data
);

    localparam int GW = $clog2(MAX_GRID + 1);
    localparam int KW = $clog2(MAX_SPREAD + 1);
    localparam int WI = $clog2(2 * MAX_SPREAD);

    logic [6:0]    grid_size_reg;
    logic [3:0]    spread_reg;
    logic [GW-1:0] g_eff;
    logic [KW-1:0] msp;
    ggs_pkg::cmd_t cmd;
    ggs_pkg::sts_t sts;
    logic [WI-1:0] a_idx;
    logic [WI-1:0] b_idx;
    logic [KW-1:0] k_idx;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= ggs_pkg::GRID_SIZE_RESET;
            spread_reg    <= ggs_pkg::SPREAD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == ggs_pkg::CFG_GRID_SIZE)
            begin
                grid_size_reg <= cfg_data;
            end
            else if (cfg_index == ggs_pkg::CFG_SPREAD)
            begin
                spread_reg <= cfg_data[3:0];
            end
        end
    end

    always_comb
    begin
        priority if (grid_size_reg < 7'd4)
            g_eff = GW'(4);
        else if (32'(grid_size_reg) > MAX_GRID)
            g_eff = GW'(MAX_GRID);
        else
            g_eff = GW'(grid_size_reg);
        priority if (spread_reg == 4'd0)
            msp = KW'(1);
        else if (32'(spread_reg) > MAX_SPREAD)
            msp = KW'(MAX_SPREAD);
        else
            msp = KW'(spread_reg);
    end

    ggs_ctrl #(
        .MAX_SPREAD (MAX_SPREAD)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (item.action),
        .msp    (msp),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy),
        .a_idx  (a_idx),
        .b_idx  (b_idx),
        .k_idx  (k_idx)
    );

    ggs_datapath #(
        .MAX_GRID   (MAX_GRID),
        .MAX_SPREAD (MAX_SPREAD)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .g_eff        (g_eff),
        .cmd          (cmd),
        .a_idx        (a_idx),
        .b_idx        (b_idx),
        .k_idx        (k_idx),
        .sts          (sts),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

FILE: src/ggs_datapath.sv
// ----------------------------------------------------------------------------
// Gaussian gridding spreader datapath
// Grid memory, reciprocal divider, kernel weight builder and the
// read-modify-write accumulate pipeline.
// ----------------------------------------------------------------------------
module ggs_datapath #(
    parameter int MAX_GRID   = ggs_pkg::DEF_MAX_GRID,
    parameter int MAX_SPREAD = ggs_pkg::DEF_MAX_SPREAD,
    localparam int GW    = $clog2(MAX_GRID + 1),
    localparam int KW    = $clog2(MAX_SPREAD + 1),
    localparam int WI    = $clog2(2 * MAX_SPREAD)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ggs_pkg::in_item_t   item,
    input  logic [GW-1:0]       g_eff,
    input  ggs_pkg::cmd_t       cmd,
    input  logic [WI-1:0]       a_idx,
    input  logic [WI-1:0]       b_idx,
    input  logic [KW-1:0]       k_idx,
    output ggs_pkg::sts_t       sts,
    output ggs_pkg::out_item_t  result,
    output logic                result_valid
);

    localparam int PW    = $clog2(MAX_GRID);
    localparam int CW    = (GW > 6) ? GW : 6;
    localparam int DEPTH = MAX_GRID * MAX_GRID;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = 2 * MAX_SPREAD;

    localparam logic signed [49:0] MAX48 = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [49:0] MIN48 = -50'sh0_8000_0000_0000;

    function automatic logic [31:0] qround(input logic [63:0] p);
        logic [64:0] r;
        begin
            r = {1'b0, p} + 65'd32768;
            qround = (|r[64:48]) ? ggs_pkg::SAT32 : r[47:16];
        end
    endfunction

    function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] p, input logic [GW-1:0] g);
        begin
            pos_inc = (GW'(p) == g - GW'(1)) ? '0 : p + PW'(1);
        end
    endfunction

    function automatic logic [PW-1:0] pos_dec(input logic [PW-1:0] p, input logic [GW-1:0] g);
        begin
            pos_dec = (p == '0) ? PW'(g - GW'(1)) : p - PW'(1);
        end
    endfunction

    ggs_pkg::in_item_t item_reg;
    logic [16:0]       tap_reg [MAX_SPREAD+1];
    logic [CW-1:0]     red_row_reg;
    logic [CW-1:0]     red_col_reg;
    logic [AW-1:0]     clr_cnt_reg;

    // Reciprocal divider.
    logic [17:0] div_rem_reg;
    logic [32:0] div_sh_reg;
    logic [5:0]  div_cnt_reg;
    logic [18:0] div_trial;
    logic [17:0] div_den;
    logic [31:0] inv;

    // Kernel weight builder.
    logic [31:0] pp_reg;
    logic [31:0] pn_reg;
    logic [63:0] mprod_reg;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] wx_reg [NW];
    logic [31:0] wy_reg [NW];
    logic [KW:0] k2;
    logic [WI-1:0] wp_idx;
    logic [WI-1:0] wn_idx;
    logic [17:0] decay;

    // Grid positions.
    logic [PW-1:0] row_base;
    logic [PW-1:0] col_base;
    logic [PW-1:0] row_cur_reg, row_p_reg, row_n_reg;
    logic [PW-1:0] col_cur_reg, col_p_reg, col_n_reg;

    // Accumulate pipeline.
    logic [AW-1:0]        addr0;
    logic [AW-1:0]        addr1_reg, addr2_reg, addr3_reg;
    logic                 v1_reg, v2_reg, v3_reg;
    logic [63:0]          wprod1_reg;
    logic [31:0]          w2_reg;
    logic [95:0]          rdq_reg;
    logic [95:0]          old2_reg;
    logic [95:0]          old3_reg;
    logic signed [48:0]   pre_re3_reg, pre_im3_reg;
    logic signed [48:0]   con_re, con_im;
    logic signed [49:0]   sum_re, sum_im;
    logic signed [47:0]   new_re, new_im;

    // Grid memory.
    logic [95:0]   mem [DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [95:0]   mem_wd;
    logic [AW-1:0] mem_ra;
    logic [AW-1:0] rd_addr;

    assign row_base = red_row_reg[PW-1:0];
    assign col_base = red_col_reg[PW-1:0];
    assign decay    = cmd.axis ? item_reg.decay_y : item_reg.decay_x;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= item;
            if (item.action == ggs_pkg::ACT_LOAD && 32'(item.tap_index) <= MAX_SPREAD)
            begin
                tap_reg[KW'(item.tap_index)] <= item.tap_value;
            end
        end
    end

    // Row and column reduction modulo the grid side, one subtract a cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            red_row_reg <= CW'(item.row);
            red_col_reg <= CW'(item.col);
        end
        else if (cmd.reduce)
        begin
            if (red_row_reg >= CW'(g_eff))
            begin
                red_row_reg <= red_row_reg - CW'(g_eff);
            end
            if (red_col_reg >= CW'(g_eff))
            begin
                red_col_reg <= red_col_reg - CW'(g_eff);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    // Restoring division of 2^32 + decay/2 by decay, one quotient bit a cycle.
    assign div_den   = decay;
    assign div_trial = {div_rem_reg, div_sh_reg[32]};
    assign inv       = div_sh_reg[32] ? ggs_pkg::SAT32 : div_sh_reg[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            div_cnt_reg <= 6'd33;
        end
        else if (div_cnt_reg != '0)
        begin
            div_cnt_reg <= div_cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            div_rem_reg <= '0;
            div_sh_reg  <= {1'b1, 32'(decay >> 1)};
        end
        else if (div_cnt_reg != '0)
        begin
            if (div_trial >= {1'b0, div_den})
            begin
                div_rem_reg <= 18'(div_trial - {1'b0, div_den});
                div_sh_reg  <= {div_sh_reg[31:0], 1'b1};
            end
            else
            begin
                div_rem_reg <= div_trial[17:0];
                div_sh_reg  <= {div_sh_reg[31:0], 1'b0};
            end
        end
    end

    // Weight builder: one shared multiplier, result rounded in the next cycle.
    assign k2     = {k_idx, 1'b0};
    assign wp_idx = WI'(k2 - (KW+1)'(1));
    assign wn_idx = WI'(k2);

    always_comb
    begin
        unique case (cmd.op)
            ggs_pkg::OP_PP:
            begin
                mul_a = pp_reg;
                mul_b = 32'(decay);
            end
            ggs_pkg::OP_PN:
            begin
                mul_a = pn_reg;
                mul_b = inv;
            end
            ggs_pkg::OP_WP:
            begin
                mul_a = 32'(tap_reg[k_idx]);
                mul_b = pp_reg;
            end
            default:
            begin
                mul_a = 32'(tap_reg[k_idx]);
                mul_b = pn_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_go)
        begin
            mprod_reg <= mul_a * mul_b;
        end
        if (cmd.winit)
        begin
            pp_reg <= ggs_pkg::Q16_ONE;
            pn_reg <= ggs_pkg::Q16_ONE;
            if (cmd.axis)
            begin
                wy_reg[0] <= 32'(tap_reg[0]);
            end
            else
            begin
                wx_reg[0] <= 32'(tap_reg[0]);
            end
        end
        else if (cmd.wb_go)
        begin
            unique case (cmd.op)
                ggs_pkg::OP_PP: pp_reg <= qround(mprod_reg);
                ggs_pkg::OP_PN: pn_reg <= qround(mprod_reg);
                ggs_pkg::OP_WP:
                begin
                    if (cmd.axis)
                    begin
                        wy_reg[wp_idx] <= qround(mprod_reg);
                    end
                    else
                    begin
                        wx_reg[wp_idx] <= qround(mprod_reg);
                    end
                end
                default:
                begin
                    if (cmd.axis)
                    begin
                        wy_reg[wn_idx] <= qround(mprod_reg);
                    end
                    else
                    begin
                        wx_reg[wn_idx] <= qround(mprod_reg);
                    end
                end
            endcase
        end
    end

    // Positions follow the offset order 0, +1, -1, +2, -2, ...
    always_ff @(posedge clk)
    begin
        if (cmd.pos_init || cmd.row_reset)
        begin
            row_cur_reg <= row_base;
            row_p_reg   <= row_base;
            row_n_reg   <= row_base;
        end
        else if (cmd.row_step)
        begin
            if (cmd.row_odd)
            begin
                row_p_reg   <= pos_inc(row_p_reg, g_eff);
                row_cur_reg <= pos_inc(row_p_reg, g_eff);
            end
            else
            begin
                row_n_reg   <= pos_dec(row_n_reg, g_eff);
                row_cur_reg <= pos_dec(row_n_reg, g_eff);
            end
        end
        if (cmd.pos_init)
        begin
            col_cur_reg <= col_base;
            col_p_reg   <= col_base;
            col_n_reg   <= col_base;
        end
        else if (cmd.col_step)
        begin
            if (cmd.col_odd)
            begin
                col_p_reg   <= pos_inc(col_p_reg, g_eff);
                col_cur_reg <= pos_inc(col_p_reg, g_eff);
            end
            else
            begin
                col_n_reg   <= pos_dec(col_n_reg, g_eff);
                col_cur_reg <= pos_dec(col_n_reg, g_eff);
            end
        end
    end

    assign addr0   = AW'(col_cur_reg) * AW'(MAX_GRID) + AW'(row_cur_reg);
    assign rd_addr = AW'(col_base) * AW'(MAX_GRID) + AW'(row_base);

    // Accumulate pipeline: read, weight, scale, saturating add and write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        addr1_reg   <= addr0;
        wprod1_reg  <= wx_reg[a_idx] * wy_reg[b_idx];
        addr2_reg   <= addr1_reg;
        w2_reg      <= qround(wprod1_reg);
        old2_reg    <= rdq_reg;
        addr3_reg   <= addr2_reg;
        old3_reg    <= old2_reg;
        pre_re3_reg <= item_reg.sample_re * $signed({1'b0, w2_reg});
        pre_im3_reg <= item_reg.sample_im * $signed({1'b0, w2_reg});
    end

    assign con_re = (pre_re3_reg + 49'sd1) >>> 1;
    assign con_im = (pre_im3_reg + 49'sd1) >>> 1;
    assign sum_re = $signed({{2{old3_reg[95]}}, old3_reg[95:48]}) + 50'(con_re);
    assign sum_im = $signed({{2{old3_reg[47]}}, old3_reg[47:0]}) + 50'(con_im);

    always_comb
    begin
        priority if (sum_re > MAX48)
            new_re = MAX48[47:0];
        else if (sum_re < MIN48)
            new_re = MIN48[47:0];
        else
            new_re = sum_re[47:0];
        priority if (sum_im > MAX48)
            new_im = MAX48[47:0];
        else if (sum_im < MIN48)
            new_im = MIN48[47:0];
        else
            new_im = sum_im[47:0];
    end

    always_comb
    begin
        mem_ra = cmd.rd_issue ? rd_addr : addr0;
        priority if (cmd.clear)
        begin
            mem_we = 1'b1;
            mem_wa = clr_cnt_reg;
            mem_wd = '0;
        end
        else if (v3_reg)
        begin
            mem_we = 1'b1;
            mem_wa = addr3_reg;
            mem_wd = {new_re, new_im};
        end
        else if (cmd.capture)
        begin
            mem_we = 1'b1;
            mem_wa = rd_addr;
            mem_wd = '0;
        end
        else
        begin
            mem_we = 1'b0;
            mem_wa = rd_addr;
            mem_wd = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rdq_reg <= mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= cmd.capture;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            result.cell_re <= rdq_reg[95:48];
            result.cell_im <= rdq_reg[47:0];
        end
    end

    assign sts.clear_last = (clr_cnt_reg == AW'(DEPTH - 1));
    assign sts.reduced    = (red_row_reg < CW'(g_eff)) && (red_col_reg < CW'(g_eff));
    assign sts.div_done   = (div_cnt_reg == '0);
    assign sts.hazard     = (v1_reg && addr1_reg == addr0) || (v2_reg && addr2_reg == addr0)
                          || (v3_reg && addr3_reg == addr0);
    assign sts.pipe_busy  = v1_reg || v2_reg || v3_reg;

    // No two items in flight share a cell, nor a capture an accumulate write.
    a_no_dup_23: assert property (@(posedge clk) disable iff (!rst_n)
        !(v2_reg && v3_reg && addr2_reg == addr3_reg))
        else $error("cells in flight share an address");
    a_no_dup_13: assert property (@(posedge clk) disable iff (!rst_n)
        !(v1_reg && v3_reg && addr1_reg == addr3_reg))
        else $error("cells in flight share an address");
    a_no_cap_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(v3_reg && cmd.capture))
        else $error("read and clear collides with an accumulate write");
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(cmd.capture))
        else $error("result strobe without a capture");

endmodule

FILE: src/ggs_ctrl.sv
// ----------------------------------------------------------------------------
// Gaussian gridding spreader controller
// Sequences clearing, reduction, weight building, cell accumulation and reads.
// ----------------------------------------------------------------------------
module ggs_ctrl #(
    parameter int MAX_SPREAD = ggs_pkg::DEF_MAX_SPREAD,
    localparam int KW = $clog2(MAX_SPREAD + 1),
    localparam int WI = $clog2(2 * MAX_SPREAD)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [1:0]     action,
    input  logic [KW-1:0]  msp,
    input  ggs_pkg::sts_t  sts,
    output ggs_pkg::cmd_t  cmd,
    output logic           busy,
    output logic [WI-1:0]  a_idx,
    output logic [WI-1:0]  b_idx,
    output logic [KW-1:0]  k_idx
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_DIVGO,
        ST_DIV,
        ST_WINIT,
        ST_MUL,
        ST_WB,
        ST_CINIT,
        ST_CELL,
        ST_DRAIN,
        ST_RD,
        ST_RDW
    } state_t;

    state_t          state_reg;
    logic [1:0]      act_reg;
    logic            axis_reg;
    ggs_pkg::op_t    op_reg;
    logic [KW-1:0]   k_reg;
    logic [WI-1:0]   a_reg;
    logic [WI-1:0]   b_reg;
    logic [KW:0]     m2;
    logic [WI-1:0]   last_idx;
    logic            accept;
    logic            issue;

    assign m2       = {msp, 1'b0};
    assign last_idx = WI'(m2 - (KW+1)'(1));
    assign accept   = start && (state_reg == ST_IDLE);
    assign issue    = (state_reg == ST_CELL) && !sts.hazard;
    assign busy     = (state_reg != ST_IDLE);
    assign a_idx    = a_reg;
    assign b_idx    = b_reg;
    assign k_idx    = k_reg;

    always_comb
    begin
        cmd           = '0;
        cmd.accept    = accept;
        cmd.clear     = (state_reg == ST_CLEAR);
        cmd.reduce    = (state_reg == ST_REDUCE);
        cmd.div_start = (state_reg == ST_DIVGO);
        cmd.winit     = (state_reg == ST_WINIT);
        cmd.mul_go    = (state_reg == ST_MUL);
        cmd.wb_go     = (state_reg == ST_WB);
        cmd.op        = op_reg;
        cmd.axis      = axis_reg;
        cmd.pos_init  = (state_reg == ST_CINIT);
        cmd.issue     = issue;
        cmd.row_reset = issue && (a_reg == last_idx);
        cmd.row_step  = issue && (a_reg != last_idx);
        cmd.row_odd   = !a_reg[0];
        cmd.col_step  = issue && (a_reg == last_idx) && (b_reg != last_idx);
        cmd.col_odd   = !b_reg[0];
        cmd.rd_issue  = (state_reg == ST_RD);
        cmd.capture   = (state_reg == ST_RDW);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            act_reg   <= ggs_pkg::ACT_LOAD;
            axis_reg  <= 1'b0;
            op_reg    <= ggs_pkg::OP_PP;
            k_reg     <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (sts.clear_last)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept && (action == ggs_pkg::ACT_SPREAD
                                   || action == ggs_pkg::ACT_READ))
                    begin
                        act_reg   <= action;
                        state_reg <= ST_REDUCE;
                    end
                end
                ST_REDUCE:
                begin
                    if (sts.reduced)
                    begin
                        axis_reg  <= 1'b0;
                        state_reg <= (act_reg == ggs_pkg::ACT_READ) ? ST_RD : ST_DIVGO;
                    end
                end
                ST_DIVGO:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (sts.div_done)
                    begin
                        state_reg <= ST_WINIT;
                    end
                end
                ST_WINIT:
                begin
                    k_reg     <= KW'(1);
                    op_reg    <= ggs_pkg::OP_PP;
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    state_reg <= ST_WB;
                end
                ST_WB:
                begin
                    unique case (op_reg)
                        ggs_pkg::OP_PP:
                        begin
                            op_reg    <= ggs_pkg::OP_PN;
                            state_reg <= ST_MUL;
                        end
                        ggs_pkg::OP_PN:
                        begin
                            op_reg    <= ggs_pkg::OP_WP;
                            state_reg <= ST_MUL;
                        end
                        ggs_pkg::OP_WP:
                        begin
                            if (k_reg < msp)
                            begin
                                op_reg    <= ggs_pkg::OP_WN;
                                state_reg <= ST_MUL;
                            end
                            else if (!axis_reg)
                            begin
                                axis_reg  <= 1'b1;
                                state_reg <= ST_DIVGO;
                            end
                            else
                            begin
                                state_reg <= ST_CINIT;
                            end
                        end
                        default:
                        begin
                            k_reg     <= k_reg + KW'(1);
                            op_reg    <= ggs_pkg::OP_PP;
                            state_reg <= ST_MUL;
                        end
                    endcase
                end
                ST_CINIT:
                begin
                    a_reg     <= '0;
                    b_reg     <= '0;
                    state_reg <= ST_CELL;
                end
                ST_CELL:
                begin
                    if (issue)
                    begin
                        if (a_reg == last_idx)
                        begin
                            a_reg <= '0;
                            if (b_reg == last_idx)
                            begin
                                state_reg <= ST_DRAIN;
                            end
                            else
                            begin
                                b_reg <= b_reg + WI'(1);
                            end
                        end
                        else
                        begin
                            a_reg <= a_reg + WI'(1);
                        end
                    end
                end
                ST_DRAIN:
                begin
                    if (!sts.pipe_busy)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_RDW;
                end
                ST_RDW:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: verif/gaussian_gridding_2d_spreader_unit_test.sv
// ----------------------------------------------------------------------------
// Gaussian gridding 2D spreader unit testbench
// Drives tap loads, sample spreads and cell reads through the command port,
// predicts every cell read with a local model of the kernel arithmetic and
// checks the results field by field over several grid and kernel settings.
// ----------------------------------------------------------------------------
module gaussian_gridding_2d_spreader_unit_test;

    localparam int GRID_MAX    = 64;
    localparam int SPREAD_MAX  = 8;
    localparam int CYCLE_LIMIT = 6000000;
    localparam int SETTLE      = 1500;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 135;
    localparam logic [63:0] WSAT = 64'hFFFF_FFFF;
    localparam longint CELL_MAX = 64'sh7FFF_FFFF_FFFF;
    localparam longint CELL_MIN = -CELL_MAX - 1;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    ggs_pkg::in_item_t  item = '0;
    ggs_pkg::out_item_t result;
    logic               result_valid;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [6:0]         cfg_data = '0;

    gaussian_gridding_2d_spreader_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result       (result),
        .result_valid (result_valid),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Local copy of the block state.
    longint     grid_re [GRID_MAX*GRID_MAX];
    longint     grid_im [GRID_MAX*GRID_MAX];
    logic [16:0] taps [SPREAD_MAX+1];
    logic [6:0] grid_size_reg = ggs_pkg::GRID_SIZE_RESET;
    logic [3:0] spread_reg = ggs_pkg::SPREAD_RESET;

    int          axis_off [2][2*SPREAD_MAX];
    logic [63:0] axis_w [2][2*SPREAD_MAX];
    int          axis_n [2];

    ggs_pkg::in_item_t  pending_items [$];
    ggs_pkg::out_item_t expected_cells [$];
    logic [5:0] spot_row [$];
    logic [5:0] spot_col [$];

    int  issued = 0;
    int  accepted = 0;
    int  cfg_writes = 0;
    int  mismatches = 0;
    int  cells_checked = 0;
    int  spreads_done = 0;
    int  loads_done = 0;
    int  cycles = 0;
    int  gap_left = 0;
    bit  idle_on = 1'b1;

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [63:0] q16_mul(logic [63:0] a, logic [63:0] b);
        logic [63:0] r;
        r = (a * b + 64'd32768) >> 16;
        return (r > WSAT) ? WSAT : r;
    endfunction

    function automatic longint add_sat48(longint a, longint b);
        longint s;
        s = a + b;
        if (s > CELL_MAX)
            return CELL_MAX;
        if (s < CELL_MIN)
            return CELL_MIN;
        return s;
    endfunction

    function automatic int wrap_index(int base, int off, int g);
        int r;
        r = (base + off) % g;
        if (r < 0)
            r += g;
        return r;
    endfunction

    // Axis weights in visiting order 0, +1, -1, ..., +msp.
    function automatic void build_axis(int ax, logic [17:0] decay, int msp);
        logic [63:0] inv;
        logic [63:0] pp;
        logic [63:0] pn;
        int n;
        pp = 64'd65536;
        pn = 64'd65536;
        if (decay == 0)
            inv = WSAT;
        else
        begin
            inv = ((64'd1 << 32) + (decay >> 1)) / decay;
            if (inv > WSAT)
                inv = WSAT;
        end
        axis_off[ax][0] = 0;
        axis_w[ax][0] = q16_mul(taps[0], 64'd65536);
        n = 1;
        for (int k = 1; k <= msp; k++)
        begin
            pp = q16_mul(pp, decay);
            pn = q16_mul(pn, inv);
            axis_off[ax][n] = k;
            axis_w[ax][n] = q16_mul(taps[k], pp);
            n++;
            if (k < msp)
            begin
                axis_off[ax][n] = -k;
                axis_w[ax][n] = q16_mul(taps[k], pn);
                n++;
            end
        end
        axis_n[ax] = n;
    endfunction

    function automatic void predict_item(ggs_pkg::in_item_t it);
        int g;
        int msp;
        int r0;
        int c0;
        int c;
        int addr;
        longint wt;
        longint sre;
        longint sim;
        ggs_pkg::out_item_t exp_cell;
        g = grid_size_reg;
        msp = spread_reg;
        if (g < 4)
            g = 4;
        if (g > GRID_MAX)
            g = GRID_MAX;
        if (msp < 1)
            msp = 1;
        if (msp > SPREAD_MAX)
            msp = SPREAD_MAX;
        r0 = it.row % g;
        c0 = it.col % g;
        case (it.action)
            ggs_pkg::ACT_LOAD:
            begin
                if (it.tap_index <= SPREAD_MAX)
                    taps[it.tap_index] = it.tap_value;
                loads_done++;
            end
            ggs_pkg::ACT_SPREAD:
            begin
                sre = $signed(it.sample_re);
                sim = $signed(it.sample_im);
                build_axis(0, it.decay_x, msp);
                build_axis(1, it.decay_y, msp);
                for (int b = 0; b < axis_n[1]; b++)
                begin
                    c = wrap_index(c0, axis_off[1][b], g);
                    for (int a = 0; a < axis_n[0]; a++)
                    begin
                        addr = c * GRID_MAX + wrap_index(r0, axis_off[0][a], g);
                        wt = longint'(q16_mul(axis_w[0][a], axis_w[1][b]));
                        grid_re[addr] = add_sat48(grid_re[addr], (sre * wt + 1) >>> 1);
                        grid_im[addr] = add_sat48(grid_im[addr], (sim * wt + 1) >>> 1);
                    end
                end
                spreads_done++;
            end
            ggs_pkg::ACT_READ:
            begin
                addr = c0 * GRID_MAX + r0;
                exp_cell.cell_re = grid_re[addr][47:0];
                exp_cell.cell_im = grid_im[addr][47:0];
                expected_cells.push_back(exp_cell);
                grid_re[addr] = 0;
                grid_im[addr] = 0;
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [47:0] want, logic [47:0] got);
        $display("MISMATCH %s: expected %h, got %h (cycle %0d)", what, want, got, cycles);
        mismatches++;
    endtask

    // Command driver: holds an item until accepted, with random idle bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_left = 0;
        end
        else if (!(start && busy))
        begin
            if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left--;
            end
            else if (pending_items.size() > 0)
            begin
                item <= pending_items.pop_front();
                start <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0)
                    gap_left = $urandom_range(1, 10);
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: predicts accepted items, applies register writes, checks cells.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predict_item(item);
                accepted++;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == ggs_pkg::CFG_GRID_SIZE)
                    grid_size_reg = cfg_data;
                else if (cfg_index == ggs_pkg::CFG_SPREAD)
                    spread_reg = cfg_data[3:0];
                cfg_valid <= 1'b0;
                cfg_writes++;
            end
            if (result_valid)
            begin
                if (expected_cells.size() == 0)
                begin
                    report_mismatch("unexpected cell_re", 48'd0, result.cell_re);
                end
                else
                begin
                    ggs_pkg::out_item_t want;
                    want = expected_cells.pop_front();
                    if (result.cell_re !== want.cell_re)
                        report_mismatch("cell_re", want.cell_re, result.cell_re);
                    if (result.cell_im !== want.cell_im)
                        report_mismatch("cell_im", want.cell_im, result.cell_im);
                    cells_checked++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic ggs_pkg::in_item_t make_item(logic [1:0] act, int r, int c);
        ggs_pkg::in_item_t it;
        it.action = act;
        it.tap_index = 4'($urandom);
        it.tap_value = 17'($urandom);
        it.sample_re = 16'($urandom);
        it.sample_im = 16'($urandom);
        it.row = 6'(r);
        it.col = 6'(c);
        it.decay_x = 18'($urandom);
        it.decay_y = 18'($urandom);
        return it;
    endfunction

    function automatic logic [17:0] pick_decay();
        int p;
        p = $urandom_range(0, 3);
        if (p == 0)
            return 18'($urandom_range(0, 262143));
        if (p == 1)
            return 18'($urandom_range(90000, 262143));
        return 18'($urandom_range(52000, 80000));
    endfunction

    task automatic queue_item(ggs_pkg::in_item_t it);
        pending_items.push_back(it);
        issued++;
    endtask

    task automatic queue_load(int idx, int val);
        ggs_pkg::in_item_t it;
        it = make_item(ggs_pkg::ACT_LOAD, $urandom, $urandom);
        it.tap_index = 4'(idx);
        it.tap_value = 17'(val);
        queue_item(it);
    endtask

    task automatic queue_spread(int r, int c, int re, int im, int dx, int dy);
        ggs_pkg::in_item_t it;
        it = make_item(ggs_pkg::ACT_SPREAD, r, c);
        it.sample_re = 16'(re);
        it.sample_im = 16'(im);
        it.decay_x = 18'(dx);
        it.decay_y = 18'(dy);
        queue_item(it);
    endtask

    // Mostly spreads and reads near earlier spreads, with some tap reloads
    // and noise that the block ignores.
    task automatic queue_random(int count);
        ggs_pkg::in_item_t it;
        int useful;
        int p;
        int k;
        useful = 0;
        while (useful < count)
        begin
            p = $urandom_range(0, 99);
            if (p < 5)
                it = make_item(ggs_pkg::ACT_UNUSED, $urandom, $urandom);
            else if (p < 13)
            begin
                it = make_item(ggs_pkg::ACT_LOAD, $urandom, $urandom);
                if ($urandom_range(0, 3) != 0)
                    it.tap_index = 4'($urandom_range(0, SPREAD_MAX));
                if ($urandom_range(0, 1) != 0)
                    it.tap_value = 17'($urandom_range(0, 65536));
            end
            else if (p < 55)
            begin
                it = make_item(ggs_pkg::ACT_SPREAD, $urandom, $urandom);
                it.decay_x = pick_decay();
                it.decay_y = pick_decay();
                if ($urandom_range(0, 3) == 0)
                begin
                    it.sample_re = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                    it.sample_im = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                end
                spot_row.push_back(it.row);
                spot_col.push_back(it.col);
                if (spot_row.size() > 16)
                begin
                    void'(spot_row.pop_front());
                    void'(spot_col.pop_front());
                end
            end
            else
            begin
                it = make_item(ggs_pkg::ACT_READ, $urandom, $urandom);
                if (spot_row.size() > 0 && $urandom_range(0, 3) != 0)
                begin
                    k = $urandom_range(0, spot_row.size() - 1);
                    it.row = 6'(spot_row[k] + $urandom_range(0, 4) - 2);
                    it.col = 6'(spot_col[k] + $urandom_range(0, 4) - 2);
                end
            end
            queue_item(it);
            if (it.action != ggs_pkg::ACT_UNUSED
                && !(it.action == ggs_pkg::ACT_LOAD && it.tap_index > SPREAD_MAX))
                useful++;
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [6:0] val);
        int n;
        n = cfg_writes;
        @(posedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        wait (cfg_writes == n + 1);
    endtask

    // A spread gives no result, so the block may still be busy after the
    // last cell arrives; give it its full spread latency.
    task automatic wait_drained();
        wait (accepted == issued && expected_cells.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        int ph_grid [PHASES];
        int ph_spread [PHASES];
        ph_grid = '{64, 4, 0, 127, 4, 37, 16, 64};
        ph_spread = '{6, 1, 0, 15, 8, 3, 2, 8};
        for (int i = 0; i < GRID_MAX*GRID_MAX; i++)
        begin
            grid_re[i] = 0;
            grid_im[i] = 0;
        end
        for (int i = 0; i <= SPREAD_MAX; i++)
            taps[i] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset settings: every tap, ignored loads,
        // the unused action, extreme samples and decays, wrap at the edges.
        queue_load(0, 65536);
        queue_load(1, 60000);
        queue_load(2, 50000);
        queue_load(3, 38000);
        queue_load(4, 26000);
        queue_load(5, 16000);
        queue_load(6, 9000);
        queue_load(7, 131071);
        queue_load(8, 0);
        queue_load(15, 1234);
        queue_load(9, 77);
        queue_item(make_item(ggs_pkg::ACT_UNUSED, 5, 5));
        queue_item(make_item(ggs_pkg::ACT_READ, 0, 0));
        queue_spread(0, 0, 32767, -32768, 65536, 65536);
        queue_spread(63, 63, -32768, 32767, 0, 262143);
        queue_spread(62, 1, 1, -1, 1, 131071);
        queue_spread(0, 0, 32767, 32767, 262143, 262143);
        queue_item(make_item(ggs_pkg::ACT_READ, 0, 0));
        queue_item(make_item(ggs_pkg::ACT_READ, 63, 63));
        queue_item(make_item(ggs_pkg::ACT_READ, 1, 0));
        queue_item(make_item(ggs_pkg::ACT_READ, 58, 0));
        queue_item(make_item(ggs_pkg::ACT_READ, 62, 1));
        queue_item(make_item(ggs_pkg::ACT_READ, 0, 0));
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_reg(ggs_pkg::CFG_GRID_SIZE, 7'(ph_grid[ph]));
            write_reg(ggs_pkg::CFG_SPREAD, 7'(ph_spread[ph]));
            if (ph == PHASES - 1)
                idle_on = 1'b0;
            queue_random(PHASE_ITEMS);
            wait_drained();
        end

        $display("ran %0d items: %0d tap loads, %0d spreads, %0d cell reads checked",
                 accepted, loads_done, spreads_done, cells_checked);
        $display("%0d register writes over %0d grid and kernel settings", cfg_writes, PHASES);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: sim.f
src/ggs_pkg.sv
src/ggs_datapath.sv
src/ggs_ctrl.sv
src/gaussian_gridding_2d_spreader_unit.sv
verif/gaussian_gridding_2d_spreader_unit_test.sv
